/* hdl/pulse_width_frame_transmitter_top_defines.svh */
// assertion macros used by the checker file
`ifndef PULSE_WIDTH_FRAME_TRANSMITTER_TOP_DEFINES_SVH
`define PULSE_WIDTH_FRAME_TRANSMITTER_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define PWFT_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PWFT_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define PWFT_ASSERT_NXT_ALL(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) (ant) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pwft_pkg.sv */
// types and constants of the pulse width frame transmitter
package pwft_pkg;

  localparam int unsigned DUR_W      = 10;
  localparam int unsigned TICKS_W    = 11;
  localparam int unsigned CYCLES_W   = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 10;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PRE_HALF   = 8'd0;
  localparam cfg_idx_t CFG_PRE_CYCLES = 8'd1;
  localparam cfg_idx_t CFG_SYNC_LOW   = 8'd2;
  localparam cfg_idx_t CFG_SYNC_HIGH  = 8'd3;
  localparam cfg_idx_t CFG_SYNC_GAP   = 8'd4;
  localparam cfg_idx_t CFG_BIT_GAP    = 8'd5;
  localparam cfg_idx_t CFG_ZERO_HIGH  = 8'd6;
  localparam cfg_idx_t CFG_ONE_EXTRA  = 8'd7;

  localparam logic [DUR_W-1:0]    RST_PRE_HALF   = 10'd300;
  localparam logic [CYCLES_W-1:0] RST_PRE_CYCLES = 6'd16;
  localparam logic [DUR_W-1:0]    RST_SYNC_LOW   = 10'd170;
  localparam logic [DUR_W-1:0]    RST_SYNC_HIGH  = 10'd80;
  localparam logic [DUR_W-1:0]    RST_SYNC_GAP   = 10'd100;
  localparam logic [DUR_W-1:0]    RST_BIT_GAP    = 10'd20;
  localparam logic [DUR_W-1:0]    RST_ZERO_HIGH  = 10'd80;
  localparam logic [DUR_W-1:0]    RST_ONE_EXTRA  = 10'd50;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic [DUR_W-1:0]    pre_half;
    logic [CYCLES_W-1:0] pre_cycles;
    logic [DUR_W-1:0]    sync_low;
    logic [DUR_W-1:0]    sync_high;
    logic [DUR_W-1:0]    sync_gap;
    logic [DUR_W-1:0]    bit_gap;
    logic [DUR_W-1:0]    zero_high;
    logic [DUR_W-1:0]    one_extra;
  } cfg_t;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_PRE_LOW   = 8'b0000_0010,
    PH_PRE_HIGH  = 8'b0000_0100,
    PH_SYNC_LOW  = 8'b0000_1000,
    PH_SYNC_HIGH = 8'b0001_0000,
    PH_SYNC_GAP  = 8'b0010_0000,
    PH_BIT_GAP   = 8'b0100_0000,
    PH_BIT_HIGH  = 8'b1000_0000
  } phase_t;

endpackage

/* hdl/pwft_intf.sv */
// handshake channels: send/tick items, line status results, register writes
interface pwft_cmd_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] byte_value;
  modport source (output valid, req_type, byte_value, input ready);
  modport sink (input valid, req_type, byte_value, output ready);
endinterface

interface pwft_res_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic start_accepted;
  logic frame_done;
  modport source (output valid, line_level, busy_res, start_accepted, frame_done,
                  input ready);
  modport sink (input valid, line_level, busy_res, start_accepted, frame_done,
                output ready);
endinterface

interface pwft_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/pwft_cfg_regs.sv */
// duration and count registers behind the write channel
module pwft_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  pwft_cfg_if.sink      cfg,
  output pwft_pkg::cfg_t regs
);
  import pwft_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pre_half   <= RST_PRE_HALF;
      regs.pre_cycles <= RST_PRE_CYCLES;
      regs.sync_low   <= RST_SYNC_LOW;
      regs.sync_high  <= RST_SYNC_HIGH;
      regs.sync_gap   <= RST_SYNC_GAP;
      regs.bit_gap    <= RST_BIT_GAP;
      regs.zero_high  <= RST_ZERO_HIGH;
      regs.one_extra  <= RST_ONE_EXTRA;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PRE_HALF:   regs.pre_half   <= cfg.data;
        CFG_PRE_CYCLES: regs.pre_cycles <= cfg.data[CYCLES_W-1:0];
        CFG_SYNC_LOW:   regs.sync_low   <= cfg.data;
        CFG_SYNC_HIGH:  regs.sync_high  <= cfg.data;
        CFG_SYNC_GAP:   regs.sync_gap   <= cfg.data;
        CFG_BIT_GAP:    regs.bit_gap    <= cfg.data;
        CFG_ZERO_HIGH:  regs.zero_high  <= cfg.data;
        CFG_ONE_EXTRA:  regs.one_extra  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

/* hdl/pwft_core.sv */
// frame sequencer state and result register
module pwft_core #(
  parameter int unsigned BITS_PER_FRAME = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  pwft_pkg::cfg_t regs,
  pwft_cmd_if.sink       cmd,
  pwft_res_if.source     res
);
  import pwft_pkg::*;

  localparam int unsigned BITS_W = $clog2(BITS_PER_FRAME + 1);

  phase_t                    phase, phase_next;
  logic [TICKS_W-1:0]        ticks_left, ticks_left_next;
  logic [CYCLES_W-1:0]       cycles_left, cycles_left_next;
  logic [BITS_W-1:0]         bits_left, bits_left_next;
  logic [BITS_PER_FRAME-1:0] shift_byte, shift_byte_next;
  logic                      level, level_next;
  logic                      accepted, done;
  logic                      fire;
  logic [TICKS_W-1:0]        pulse_ticks;

  assign cmd.ready = !res.valid || res.ready;
  assign fire      = cmd.valid && cmd.ready;

  assign pulse_ticks = TICKS_W'(regs.zero_high) +
                       (shift_byte[BITS_PER_FRAME-1] ? TICKS_W'(regs.one_extra) : '0);

  always_comb begin
    phase_next       = phase;
    ticks_left_next  = ticks_left;
    cycles_left_next = cycles_left;
    bits_left_next   = bits_left;
    shift_byte_next  = shift_byte;
    level_next       = level;
    accepted         = 1'b0;
    done             = 1'b0;
    if (cmd.req_type == REQ_START) begin
      if (phase == PH_IDLE) begin
        accepted         = 1'b1;
        shift_byte_next  = cmd.byte_value[BITS_PER_FRAME-1:0];
        bits_left_next   = BITS_W'(BITS_PER_FRAME);
        cycles_left_next = regs.pre_cycles;
        phase_next       = PH_PRE_LOW;
        ticks_left_next  = TICKS_W'(regs.pre_half);
        level_next       = 1'b0;
      end
    end else if (phase != PH_IDLE) begin
      if (ticks_left > TICKS_W'(1)) begin
        ticks_left_next = ticks_left - TICKS_W'(1);
      end else begin
        case (phase)
          PH_PRE_LOW: begin
            phase_next      = PH_PRE_HIGH;
            ticks_left_next = TICKS_W'(regs.pre_half);
            level_next      = 1'b1;
          end
          PH_PRE_HIGH: begin
            level_next = 1'b0;
            if (cycles_left > CYCLES_W'(1)) begin
              cycles_left_next = cycles_left - CYCLES_W'(1);
              phase_next       = PH_PRE_LOW;
              ticks_left_next  = TICKS_W'(regs.pre_half);
            end else begin
              cycles_left_next = '0;
              phase_next       = PH_SYNC_LOW;
              ticks_left_next  = TICKS_W'(regs.sync_low);
            end
          end
          PH_SYNC_LOW: begin
            phase_next      = PH_SYNC_HIGH;
            ticks_left_next = TICKS_W'(regs.sync_high);
            level_next      = 1'b1;
          end
          PH_SYNC_HIGH: begin
            phase_next      = PH_SYNC_GAP;
            ticks_left_next = TICKS_W'(regs.sync_gap);
            level_next      = 1'b0;
          end
          PH_SYNC_GAP: begin
            phase_next      = PH_BIT_GAP;
            ticks_left_next = TICKS_W'(regs.bit_gap);
            level_next      = 1'b0;
          end
          PH_BIT_GAP: begin
            phase_next      = PH_BIT_HIGH;
            ticks_left_next = pulse_ticks;
            level_next      = 1'b1;
          end
          PH_BIT_HIGH: begin
            shift_byte_next = shift_byte << 1;
            level_next      = 1'b0;
            if (bits_left > BITS_W'(1)) begin
              bits_left_next  = bits_left - BITS_W'(1);
              phase_next      = PH_BIT_GAP;
              ticks_left_next = TICKS_W'(regs.bit_gap);
            end else begin
              bits_left_next  = '0;
              done            = 1'b1;
              phase_next      = PH_IDLE;
              ticks_left_next = '0;
            end
          end
          default: begin
            phase_next      = PH_IDLE;
            ticks_left_next = '0;
            level_next      = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      ticks_left  <= '0;
      cycles_left <= '0;
      bits_left   <= '0;
      shift_byte  <= '0;
      level       <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      if (fire) begin
        phase       <= phase_next;
        ticks_left  <= ticks_left_next;
        cycles_left <= cycles_left_next;
        bits_left   <= bits_left_next;
        shift_byte  <= shift_byte_next;
        level       <= level_next;
        res.valid   <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (fire) begin
      res.line_level     <= level_next;
      res.busy_res       <= (phase_next != PH_IDLE);
      res.start_accepted <= accepted;
      res.frame_done     <= done;
    end
  end

endmodule

/* hdl/pulse_width_frame_transmitter_top.sv */
// top level of the pulse width frame transmitter
//
// cmd carries one item per request: req_type 0 starts a frame with byte_value,
// req_type 1 reports one elapsed time tick. every item gives exactly one
// result item on res: the line level after it, busy, whether a start was
// taken, and whether the last data pulse ended on it. line_level of each
// result is the wire level to drive until the next item.
// cfg writes the eight duration and count registers by index; it is always
// ready and indexes above seven are dropped.
// the result is registered and appears in the cycle after the item is taken.
// throughput: one item per cycle while res takes results, set by the single
// state update that each item makes in the sequencer.
// a finished result sits in the output register; cmd stays ready as long as
// that register is empty or is taken in the same cycle, so a stalled res
// holds one result and then stalls cmd.
// reset (rst, synchronous) puts the line low, the sequencer idle, the output
// register empty and the cfg registers at their default durations and count.
module pulse_width_frame_transmitter_top #(
  parameter int unsigned BITS_PER_FRAME = 8
) (
  input  logic       clk,
  input  logic       rst,
  pwft_cmd_if.sink   cmd,
  pwft_res_if.source res,
  pwft_cfg_if.sink   cfg
);
  import pwft_pkg::*;

  cfg_t regs;

  pwft_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  pwft_core #(
    .BITS_PER_FRAME (BITS_PER_FRAME)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .cmd  (cmd),
    .res  (res)
  );

endmodule

/* hdl/pwft_checker.sv */
// port-level checks of the transmitter, bound to the top level
`include "pulse_width_frame_transmitter_top_defines.svh"

module pwft_checker (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input logic line_level,
  input logic busy_res,
  input logic start_accepted,
  input logic frame_done
);

  logic idle_low;
  logic start_ok;

  assign idle_low = !busy_res && !line_level;
  assign start_ok = busy_res && !line_level && !frame_done;

  // a frame ends with the line low and the block idle
  `PWFT_ASSERT_IMP(a_done_idle, res_valid && frame_done, idle_low, "frame_done with line busy")

  // a taken start begins the low preamble half and cannot end a frame
  `PWFT_ASSERT_IMP(a_start_low, res_valid && start_accepted, start_ok, "bad start result")

  // the line only goes high inside a frame
  `PWFT_ASSERT_IMP(a_idle_low, res_valid && !busy_res, !line_level, "line high while idle")

  // a waiting result is not dropped
  `PWFT_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped under stall")

  // nothing comes out right after reset
  `PWFT_ASSERT_NXT_ALL(a_rst_empty, rst, !res_valid, "result valid after reset")

endmodule

bind pulse_width_frame_transmitter_top pwft_checker u_pwft_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .line_level     (res.line_level),
  .busy_res       (res.busy_res),
  .start_accepted (res.start_accepted),
  .frame_done     (res.frame_done)
);
